// File: rtl/lfu_pkg.sv
// Shared constants and control types of the LFU cache with LRU tie-break.
package lfu_pkg;

  localparam int DATA_BITS  = 32;
  localparam int STAMP_BITS = 32;
  localparam int CAP_BITS   = 5;

  // Capacity register value after reset.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Request kinds.
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

endpackage

// File: rtl/lfu_if.sv
// Request, response and configuration channel interfaces of the LFU cache.
interface lfu_req_if #(
  parameter int KEY_BITS = 16
);
  import lfu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [KEY_BITS-1:0]  key;
  logic [DATA_BITS-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lfu_rsp_if #(
  parameter int KEY_BITS = 16
);
  import lfu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DATA_BITS-1:0] read_value;
  logic                 evicted;
  logic [KEY_BITS-1:0]  evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  import lfu_pkg::*;

  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/lfu_entry_ram.sv
// Entry store: one write port and one registered read port.
module lfu_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 96,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lfu_scan_unit.sv
// Shared compare unit: key match, victim search and first free slot, one entry a step.
module lfu_scan_unit #(
  parameter int AW         = 4,
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfu_pkg::scan_ctl_t           ctl_i,
  input  logic [AW-1:0]                idx_i,
  input  logic                         ent_valid_i,
  input  logic [KEY_BITS-1:0]          req_key_i,
  input  logic [KEY_BITS-1:0]          ent_key_i,
  input  logic [lfu_pkg::DATA_BITS-1:0] ent_data_i,
  input  logic [COUNT_BITS-1:0]        ent_count_i,
  input  logic [lfu_pkg::STAMP_BITS-1:0] ent_stamp_i,
  output logic                         match_o,
  output logic [AW-1:0]                match_idx_o,
  output logic [lfu_pkg::DATA_BITS-1:0] match_data_o,
  output logic [COUNT_BITS-1:0]        match_count_o,
  output logic                         victim_found_o,
  output logic [AW-1:0]                victim_idx_o,
  output logic [KEY_BITS-1:0]          victim_key_o,
  output logic                         free_found_o,
  output logic [AW-1:0]                free_idx_o
);
  import lfu_pkg::*;

  localparam int RANK_BITS = COUNT_BITS + STAMP_BITS;

  logic                  match_q;
  logic [AW-1:0]         match_idx_q;
  logic [DATA_BITS-1:0]  match_data_q;
  logic [COUNT_BITS-1:0] match_count_q;
  logic                  victim_found_q;
  logic [AW-1:0]         victim_idx_q;
  logic [KEY_BITS-1:0]   victim_key_q;
  logic [RANK_BITS-1:0]  victim_rank_q;
  logic                  free_found_q;
  logic [AW-1:0]         free_idx_q;

  logic [RANK_BITS-1:0]  ent_rank;
  logic                  take_match;
  logic                  take_victim;
  logic                  take_free;

  // Count first, then stamp: lower rank is the better victim.
  assign ent_rank    = {ent_count_i, ent_stamp_i};
  assign take_match  = ctl_i.step && ent_valid_i && !match_q && (ent_key_i == req_key_i);
  assign take_victim = ctl_i.step && ent_valid_i &&
                       (!victim_found_q || (ent_rank < victim_rank_q));
  assign take_free   = ctl_i.step && !ent_valid_i && !free_found_q;

  // Found flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q        <= 1'b0;
      victim_found_q <= 1'b0;
      free_found_q   <= 1'b0;
    end else if (ctl_i.clear) begin
      match_q        <= 1'b0;
      victim_found_q <= 1'b0;
      free_found_q   <= 1'b0;
    end else begin
      if (take_match) begin
        match_q <= 1'b1;
      end
      if (take_victim) begin
        victim_found_q <= 1'b1;
      end
      if (take_free) begin
        free_found_q <= 1'b1;
      end
    end
  end

  // Captured entry fields.
  always_ff @(posedge clk_i) begin
    if (take_match) begin
      match_idx_q   <= idx_i;
      match_data_q  <= ent_data_i;
      match_count_q <= ent_count_i;
    end
    if (take_victim) begin
      victim_idx_q  <= idx_i;
      victim_key_q  <= ent_key_i;
      victim_rank_q <= ent_rank;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
  end

  assign match_o        = match_q;
  assign match_idx_o    = match_idx_q;
  assign match_data_o   = match_data_q;
  assign match_count_o  = match_count_q;
  assign victim_found_o = victim_found_q;
  assign victim_idx_o   = victim_idx_q;
  assign victim_key_o   = victim_key_q;
  assign free_found_o   = free_found_q;
  assign free_idx_o     = free_idx_q;

endmodule

// File: rtl/lfu_cache_lru_tiebreak_unit.sv
// Top level of the LFU cache with LRU tie-break: sequencer, valid bits and result register.
// A request is taken only in the idle state, so a new request waits until the last one is
// written back. Each request is a scan of the entry store through its single read port,
// one entry a cycle, plus a write-back.
// Reset clears the valid bits, occupancy and access clock and sets capacity to 16;
// the entry store itself is not cleared, so there is no clearing pass.
module lfu_cache_lru_tiebreak_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o,
  lfu_cfg_if.sink   cfg_i
);
  import lfu_pkg::*;

  localparam int AW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OW     = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW   = (OW > CAP_BITS) ? OW : CAP_BITS;
  localparam int WORD_W = KEY_BITS + DATA_BITS + COUNT_BITS + STAMP_BITS;

  localparam logic [AW-1:0]         LAST_IDX  = AW'(MAX_ENTRIES - 1);
  localparam logic [CMPW-1:0]       MAX_EXT   = CMPW'(MAX_ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_idx_q;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [OW-1:0]          occ_q, occ_d;
  logic [STAMP_BITS-1:0]  clock_q;
  logic [CAP_BITS-1:0]    cap_q;

  logic                   req_kind_q;
  logic [KEY_BITS-1:0]    req_key_q;
  logic [DATA_BITS-1:0]   req_value_q;
  logic [STAMP_BITS-1:0]  now_q;

  logic                   out_valid_q;
  logic                   out_hit_q;
  logic [DATA_BITS-1:0]   out_value_q;
  logic                   out_evicted_q;
  logic [KEY_BITS-1:0]    out_evkey_q;

  logic                   req_beat;
  logic                   rsp_beat;
  logic                   finish;
  scan_ctl_t              scan_ctl;

  logic [WORD_W-1:0]      rdata;
  logic [WORD_W-1:0]      wdata;
  logic [AW-1:0]          waddr;
  logic                   we;
  logic [KEY_BITS-1:0]    ent_key;
  logic [DATA_BITS-1:0]   ent_data;
  logic [COUNT_BITS-1:0]  ent_count;
  logic [STAMP_BITS-1:0]  ent_stamp;

  logic                   match;
  logic [AW-1:0]          match_idx;
  logic [DATA_BITS-1:0]   match_data;
  logic [COUNT_BITS-1:0]  match_count;
  logic                   victim_found;
  logic [AW-1:0]          victim_idx;
  logic [KEY_BITS-1:0]    victim_key;
  logic                   free_found;
  logic [AW-1:0]          free_idx;

  logic [CMPW-1:0]        cap_ext;
  logic [CMPW-1:0]        cap_eff;
  logic                   cap_zero;
  logic                   is_put;
  logic                   do_touch;
  logic                   do_evict;
  logic                   do_insert;
  logic [AW-1:0]          dst_idx;
  logic [DATA_BITS-1:0]   touch_data;
  logic [COUNT_BITS-1:0]  touch_count;

  assign req_beat    = req_i.valid && req_i.ready;
  assign rsp_beat    = rsp_o.valid && rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // The write-back waits until the previous result has been taken.
  assign finish = (state_q == ST_WRITE) && (!out_valid_q || rsp_o.ready);

  assign scan_ctl.clear = req_beat;
  assign scan_ctl.step  = pend_q;

  // Entry word layout: key, data, use count, stamp.
  assign {ent_key, ent_data, ent_count, ent_stamp} = rdata;

  lfu_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (WORD_W),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  lfu_scan_unit #(
    .AW         (AW),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (scan_ctl),
    .idx_i          (pend_idx_q),
    .ent_valid_i    (valid_q[pend_idx_q]),
    .req_key_i      (req_key_q),
    .ent_key_i      (ent_key),
    .ent_data_i     (ent_data),
    .ent_count_i    (ent_count),
    .ent_stamp_i    (ent_stamp),
    .match_o        (match),
    .match_idx_o    (match_idx),
    .match_data_o   (match_data),
    .match_count_o  (match_count),
    .victim_found_o (victim_found),
    .victim_idx_o   (victim_idx),
    .victim_key_o   (victim_key),
    .free_found_o   (free_found),
    .free_idx_o     (free_idx)
  );

  // Decision after the scan. Capacity above the store size acts as the store size.
  assign cap_ext   = CMPW'(cap_q);
  assign cap_eff   = (cap_ext > MAX_EXT) ? MAX_EXT : cap_ext;
  assign cap_zero  = (cap_q == '0);
  assign is_put    = (req_kind_q == KIND_PUT);
  assign do_touch  = match && (!is_put || !cap_zero);
  assign do_evict  = is_put && !cap_zero && !match && victim_found &&
                     (CMPW'(occ_q) >= cap_eff);
  assign do_insert = is_put && !cap_zero && !match && (do_evict || free_found);

  // After an eviction the lowest free slot may be the victim's own.
  assign dst_idx = (do_evict && !(free_found && (free_idx < victim_idx))) ? victim_idx
                                                                         : free_idx;

  assign touch_data  = is_put ? req_value_q : match_data;
  assign touch_count = (match_count == COUNT_MAX) ? COUNT_MAX : match_count + COUNT_ONE;

  // Write-back of the touched or inserted entry.
  always_comb begin
    we    = finish && (do_touch || do_insert);
    waddr = do_touch ? match_idx : dst_idx;
    if (do_touch) begin
      wdata = {req_key_q, touch_data, touch_count, now_q};
    end else begin
      wdata = {req_key_q, req_value_q, COUNT_ONE, now_q};
    end
  end

  // Valid bits and occupancy.
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    if (finish) begin
      if (do_evict) begin
        valid_d[victim_idx] = 1'b0;
      end
      if (do_insert) begin
        valid_d[dst_idx] = 1'b1;
      end
      if (do_evict && !do_insert) begin
        occ_d = occ_q - OW'(1);
      end else if (do_insert && !do_evict) begin
        occ_d = occ_q + OW'(1);
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (req_beat) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_d = 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      clock_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      occ_q   <= occ_d;
      if (req_beat) begin
        clock_q <= clock_q + STAMP_BITS'(1);
      end
      if (cfg_i.valid) begin
        cap_q <= cfg_i.data;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_beat) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    pend_idx_q <= idx_q;
    if (req_beat) begin
      req_kind_q  <= req_i.kind;
      req_key_q   <= req_i.key;
      req_value_q <= req_i.value;
      now_q       <= clock_q;
    end
    if (finish) begin
      out_hit_q     <= match;
      out_value_q   <= (!is_put && match) ? match_data : '0;
      out_evicted_q <= do_evict;
      out_evkey_q   <= do_evict ? victim_key : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.hit         = out_hit_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.evicted     = out_evicted_q;
  assign rsp_o.evicted_key = out_evkey_q;

endmodule
